@@ src/tlpt_pkg.sv @@
// Shared types and constants for the two-level page table engine.
package tlpt_pkg;

   // Entry bit positions and address split
   localparam int unsigned BIT_PRESENT  = 0;
   localparam int unsigned BIT_WRITABLE = 1;
   localparam int unsigned BIT_USER     = 2;
   localparam int unsigned BIT_ACCESSED = 5;
   localparam int unsigned BIT_LARGE    = 7;
   localparam int unsigned PAGE_BITS    = 12;
   localparam int unsigned LARGE_BITS   = 22;
   localparam int unsigned IDX_BITS     = 10;
   localparam int unsigned DIR_DEPTH    = 1 << IDX_BITS;
   localparam int unsigned FRAME_BITS   = 32 - PAGE_BITS;

   // Configuration register indexes
   localparam logic [1:0] CSR_WINDOW_BASE = 2'd0;
   localparam logic [1:0] CSR_WINDOW_SIZE = 2'd1;
   localparam logic [1:0] CSR_POOL_BASE   = 2'd2;

   typedef enum logic [2:0] {
      OP_TRANSLATE = 3'd0,
      OP_MAP       = 3'd1,
      OP_UNMAP     = 3'd2,
      OP_TEST_CLR  = 3'd3,
      OP_MAP_LARGE = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NOT_MAPPED = 3'd1,
      ST_MISALIGNED = 3'd2,
      ST_POOL_EMPTY = 3'd3,
      ST_LARGE_HIT  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PHYS_ZERO   = 2'd0,
      PHYS_WINDOW = 2'd1,
      PHYS_LARGE  = 2'd2,
      PHYS_PAGE   = 2'd3
   } phys_sel_type;

   typedef enum logic [1:0] {
      DW_ZERO      = 2'd0,
      DW_NEW_TABLE = 2'd1,
      DW_SET_USER  = 2'd2,
      DW_LARGE     = 2'd3
   } dir_wsel_type;

   typedef enum logic [1:0] {
      PW_ZERO    = 2'd0,
      PW_NEW_PTE = 2'd1,
      PW_CLR_ACC = 2'd2
   } pool_wsel_type;

   typedef enum logic [1:0] {
      PA_SLOT  = 2'd0,
      PA_ALLOC = 2'd1,
      PA_NEW   = 2'd2,
      PA_SWEEP = 2'd3
   } pool_asel_type;

   typedef struct packed {
      logic          capture;
      logic          dir_rd;
      logic          dir_wr;
      dir_wsel_type  dir_wsel;
      logic          pool_rd;
      logic          pool_wr;
      pool_wsel_type pool_wsel;
      pool_asel_type pool_asel;
      logic          sweep_clr;
      logic          sweep_inc;
      logic          alloc_inc;
      logic          res_we;
      status_type    res_status;
      phys_sel_type  res_phys;
      logic          res_acc;
      logic          res_inv;
      logic          res_freed;
      logic          rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   win_hit;
      logic   pde_present;
      logic   pde_large;
      logic   leaf_ok;
      logic   mis_page;
      logic   mis_page_va;
      logic   mis_large;
      logic   pool_full;
      logic   pte_present;
      logic   pte_accessed;
      logic   sweep_all_last;
      logic   sweep_row_last;
   } dp_status_type;

endpackage

@@ src/tlpt_datapath.sv @@
// Datapath: operand registers, directory and table pool memories, result registers.
module tlpt_datapath import tlpt_pkg::*; #(
   parameter int unsigned POOL_TABLES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         sts,
   input  logic [2:0]            req_opcode,
   input  logic [31:0]           req_virt_addr,
   input  logic [31:0]           req_phys_addr,
   input  logic [11:0]           req_entry_flags,
   input  logic [31:0]           window_base,
   input  logic [31:0]           window_size,
   input  logic [FRAME_BITS-1:0] pool_frame,
   output logic [2:0]            rsp_status,
   output logic [31:0]           rsp_phys_result,
   output logic                  rsp_was_accessed,
   output logic [31:0]           rsp_freed_frame,
   output logic                  rsp_freed_valid,
   output logic                  rsp_invalidate
);

   localparam int unsigned TW         = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
   localparam int unsigned PAW        = TW + IDX_BITS;
   localparam int unsigned POOL_DEPTH = POOL_TABLES * DIR_DEPTH;
   localparam int unsigned NTW        = $clog2(POOL_TABLES + 1);

   logic [2:0]   opcode_ff;
   logic [31:0]  va_ff;
   logic [31:0]  pa_ff;
   logic [11:0]  flags_ff;

   logic [31:0]  dir_mem [DIR_DEPTH];
   logic [31:0]  pool_mem [POOL_DEPTH];
   logic [31:0]  dir_q_ff;
   logic [31:0]  pool_q_ff;

   logic [PAW-1:0] sweep_ff, sweep_in;
   logic [NTW-1:0] next_ff, next_in;

   status_type   res_status_ff;
   logic [31:0]  res_phys_ff;
   logic         res_acc_ff;
   logic         res_inv_ff;
   logic [31:0]  res_freed_ff;
   logic         res_fvalid_ff;

   status_type   rsp_status_ff;
   logic [31:0]  rsp_phys_ff;
   logic         rsp_acc_ff;
   logic         rsp_inv_ff;
   logic [31:0]  rsp_freed_ff;
   logic         rsp_fvalid_ff;

   logic [FRAME_BITS-1:0] table_ofs;
   logic [PAW-1:0]        slot;
   logic [PAW-1:0]        pool_addr;
   logic [31:0]           pool_wdata;
   logic [IDX_BITS-1:0]   dir_waddr;
   logic [31:0]           dir_wdata;
   logic [32:0]           win_diff;
   logic [31:0]           new_pte;
   logic [31:0]           user_bit;
   logic                  freed_ok;
   logic [31:0]           phys_sel;

   // Operand capture at the input transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff <= req_opcode;
         va_ff     <= req_virt_addr;
         pa_ff     <= req_phys_addr;
         flags_ff  <= req_entry_flags;
      end
   end

   // Walk decode on the registered directory and table entries
   always_comb begin
      table_ofs = dir_q_ff[31:PAGE_BITS] - pool_frame;
      slot      = {table_ofs[TW-1:0], va_ff[PAGE_BITS +: IDX_BITS]};
      win_diff  = {1'b0, va_ff} - {1'b0, window_base};
      user_bit  = {29'd0, flags_ff[BIT_USER], 2'd0};
      new_pte   = {pa_ff[31:PAGE_BITS], {PAGE_BITS{1'b0}}} | {20'd0, flags_ff} | 32'd1;
      freed_ok  = pool_q_ff[BIT_PRESENT] && pool_q_ff[BIT_USER]
                  && (pool_q_ff[31:PAGE_BITS] != '0);

      sts.op             = op_type'(opcode_ff);
      sts.win_hit        = !win_diff[32] && (win_diff[31:0] < window_size);
      sts.pde_present    = dir_q_ff[BIT_PRESENT];
      sts.pde_large      = dir_q_ff[BIT_PRESENT] && dir_q_ff[BIT_LARGE];
      sts.leaf_ok        = dir_q_ff[BIT_PRESENT] && !dir_q_ff[BIT_LARGE]
                           && (table_ofs < FRAME_BITS'(POOL_TABLES));
      sts.mis_page       = (va_ff[PAGE_BITS-1:0] != '0) || (pa_ff[PAGE_BITS-1:0] != '0);
      sts.mis_page_va    = (va_ff[PAGE_BITS-1:0] != '0);
      sts.mis_large      = (va_ff[LARGE_BITS-1:0] != '0) || (pa_ff[LARGE_BITS-1:0] != '0);
      sts.pool_full      = (next_ff >= NTW'(POOL_TABLES));
      sts.pte_present    = pool_q_ff[BIT_PRESENT];
      sts.pte_accessed   = pool_q_ff[BIT_ACCESSED];
      sts.sweep_all_last = (sweep_ff == PAW'(POOL_DEPTH - 1));
      sts.sweep_row_last = &sweep_ff[IDX_BITS-1:0];
   end

   // Directory port selection
   always_comb begin
      dir_waddr = (cmd.dir_wsel == DW_ZERO) ? sweep_ff[IDX_BITS-1:0]
                                             : va_ff[LARGE_BITS +: IDX_BITS];
      case (cmd.dir_wsel)
         DW_ZERO:      dir_wdata = '0;
         DW_NEW_TABLE: dir_wdata = {pool_frame + FRAME_BITS'(next_ff), {PAGE_BITS{1'b0}}}
                                   | 32'd3 | user_bit;
         DW_SET_USER:  dir_wdata = dir_q_ff | user_bit;
         DW_LARGE:     dir_wdata = {pa_ff[31:LARGE_BITS], {LARGE_BITS{1'b0}}}
                                   | {20'd0, flags_ff} | 32'd1 | (32'd1 << BIT_LARGE);
         default:      dir_wdata = '0;
      endcase
   end

   // Table pool port selection
   always_comb begin
      case (cmd.pool_asel)
         PA_SLOT:  pool_addr = slot;
         PA_ALLOC: pool_addr = {next_ff[TW-1:0], sweep_ff[IDX_BITS-1:0]};
         PA_NEW:   pool_addr = {next_ff[TW-1:0], va_ff[PAGE_BITS +: IDX_BITS]};
         PA_SWEEP: pool_addr = sweep_ff;
         default:  pool_addr = slot;
      endcase
      case (cmd.pool_wsel)
         PW_ZERO:    pool_wdata = '0;
         PW_NEW_PTE: pool_wdata = new_pte;
         PW_CLR_ACC: pool_wdata = pool_q_ff & ~(32'd1 << BIT_ACCESSED);
         default:    pool_wdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.dir_wr) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      if (cmd.dir_rd) begin
         dir_q_ff <= dir_mem[req_virt_addr[LARGE_BITS +: IDX_BITS]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pool_wr) begin
         pool_mem[pool_addr] <= pool_wdata;
      end
      if (cmd.pool_rd) begin
         pool_q_ff <= pool_mem[slot];
      end
   end

   // Sweep counter and table allocation count
   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_clr) begin
         sweep_in = '0;
      end else if (cmd.sweep_inc) begin
         sweep_in = sweep_ff + PAW'(1);
      end
      next_in = cmd.alloc_inc ? next_ff + NTW'(1) : next_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         next_ff  <= '0;
      end else begin
         sweep_ff <= sweep_in;
         next_ff  <= next_in;
      end
   end

   always_comb begin
      case (cmd.res_phys)
         PHYS_ZERO:   phys_sel = '0;
         PHYS_WINDOW: phys_sel = win_diff[31:0];
         PHYS_LARGE:  phys_sel = {dir_q_ff[31:LARGE_BITS], va_ff[LARGE_BITS-1:0]};
         PHYS_PAGE:   phys_sel = {pool_q_ff[31:PAGE_BITS], va_ff[PAGE_BITS-1:0]};
         default:     phys_sel = '0;
      endcase
   end

   // Result held until the output register is free
   always_ff @(posedge clock) begin
      if (cmd.res_we) begin
         res_status_ff <= cmd.res_status;
         res_phys_ff   <= phys_sel;
         res_acc_ff    <= cmd.res_acc;
         res_inv_ff    <= cmd.res_inv;
         res_fvalid_ff <= cmd.res_freed && freed_ok;
         res_freed_ff  <= (cmd.res_freed && freed_ok)
                          ? {pool_q_ff[31:PAGE_BITS], {PAGE_BITS{1'b0}}} : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_phys_ff   <= res_phys_ff;
         rsp_acc_ff    <= res_acc_ff;
         rsp_inv_ff    <= res_inv_ff;
         rsp_freed_ff  <= res_freed_ff;
         rsp_fvalid_ff <= res_fvalid_ff;
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_phys_result  = rsp_phys_ff;
   assign rsp_was_accessed = rsp_acc_ff;
   assign rsp_freed_frame  = rsp_freed_ff;
   assign rsp_freed_valid  = rsp_fvalid_ff;
   assign rsp_invalidate   = rsp_inv_ff;

endmodule

@@ src/tlpt_ctrl.sv @@
// Controller: sequences clearing, directory and table accesses, and the result handshake.
module tlpt_ctrl import tlpt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type sts,
   output dp_cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_DIR    = 7'b0000100,
      S_PTE    = 7'b0001000,
      S_SWEEP  = 7'b0010000,
      S_MAPWR  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.dir_wsel   = DW_ZERO;
      cmd.pool_wsel  = PW_ZERO;
      cmd.pool_asel  = PA_SLOT;
      cmd.res_status = ST_NOT_MAPPED;
      cmd.res_phys   = PHYS_ZERO;

      case (state_ff)
         S_CLEAR: begin
            // zero both memories, directory rows repeat harmlessly
            cmd.dir_wr    = 1'b1;
            cmd.pool_wr   = 1'b1;
            cmd.pool_asel = PA_SWEEP;
            cmd.sweep_inc = 1'b1;
            if (sts.sweep_all_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               cmd.dir_rd  = 1'b1;
               state_in    = S_DIR;
            end
         end
         S_DIR: begin
            cmd.res_we = 1'b1;
            state_in   = S_FINISH;
            case (sts.op)
               OP_TRANSLATE: begin
                  if (sts.win_hit) begin
                     cmd.res_status = ST_OK;
                     cmd.res_phys   = PHYS_WINDOW;
                  end else if (sts.pde_large) begin
                     cmd.res_status = ST_OK;
                     cmd.res_phys   = PHYS_LARGE;
                  end else if (sts.leaf_ok) begin
                     cmd.res_we  = 1'b0;
                     cmd.pool_rd = 1'b1;
                     state_in    = S_PTE;
                  end
               end
               OP_MAP: begin
                  if (sts.mis_page) begin
                     cmd.res_status = ST_MISALIGNED;
                  end else if (sts.pde_large) begin
                     cmd.res_status = ST_LARGE_HIT;
                  end else if (!sts.pde_present && sts.pool_full) begin
                     cmd.res_status = ST_POOL_EMPTY;
                  end else if (!sts.pde_present) begin
                     // take the next pool table, then clear it
                     cmd.res_we    = 1'b0;
                     cmd.dir_wr    = 1'b1;
                     cmd.dir_wsel  = DW_NEW_TABLE;
                     cmd.sweep_clr = 1'b1;
                     state_in      = S_SWEEP;
                  end else if (sts.leaf_ok) begin
                     cmd.dir_wr     = 1'b1;
                     cmd.dir_wsel   = DW_SET_USER;
                     cmd.pool_wr    = 1'b1;
                     cmd.pool_wsel  = PW_NEW_PTE;
                     cmd.res_status = ST_OK;
                     cmd.res_inv    = 1'b1;
                  end
               end
               OP_UNMAP, OP_TEST_CLR: begin
                  if (sts.op == OP_UNMAP && sts.mis_page_va) begin
                     cmd.res_status = ST_MISALIGNED;
                  end else if (sts.leaf_ok) begin
                     cmd.res_we  = 1'b0;
                     cmd.pool_rd = 1'b1;
                     state_in    = S_PTE;
                  end
               end
               OP_MAP_LARGE: begin
                  if (sts.mis_large) begin
                     cmd.res_status = ST_MISALIGNED;
                  end else begin
                     cmd.dir_wr     = 1'b1;
                     cmd.dir_wsel   = DW_LARGE;
                     cmd.res_status = ST_OK;
                     cmd.res_inv    = 1'b1;
                  end
               end
               default: begin
                  cmd.res_status = ST_NOT_MAPPED;
               end
            endcase
         end
         S_PTE: begin
            cmd.res_we = 1'b1;
            state_in   = S_FINISH;
            case (sts.op)
               OP_TRANSLATE: begin
                  if (sts.pte_present) begin
                     cmd.res_status = ST_OK;
                     cmd.res_phys   = PHYS_PAGE;
                  end
               end
               OP_UNMAP: begin
                  cmd.pool_wr   = 1'b1;
                  cmd.res_inv   = 1'b1;
                  cmd.res_freed = 1'b1;
                  if (sts.pte_present) begin
                     cmd.res_status = ST_OK;
                  end
               end
               OP_TEST_CLR: begin
                  if (sts.pte_present) begin
                     cmd.res_status = ST_OK;
                     if (sts.pte_accessed) begin
                        cmd.pool_wr   = 1'b1;
                        cmd.pool_wsel = PW_CLR_ACC;
                        cmd.res_acc   = 1'b1;
                        cmd.res_inv   = 1'b1;
                     end
                  end
               end
               default: begin
                  cmd.res_status = ST_NOT_MAPPED;
               end
            endcase
         end
         S_SWEEP: begin
            cmd.pool_wr   = 1'b1;
            cmd.pool_asel = PA_ALLOC;
            cmd.sweep_inc = 1'b1;
            if (sts.sweep_row_last) begin
               state_in = S_MAPWR;
            end
         end
         S_MAPWR: begin
            cmd.pool_wr    = 1'b1;
            cmd.pool_wsel  = PW_NEW_PTE;
            cmd.pool_asel  = PA_NEW;
            cmd.alloc_inc  = 1'b1;
            cmd.res_we     = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_inv    = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register drains
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/two_level_page_table_engine.sv @@
// Top level: configuration registers, controller and datapath of the page table engine.
//
//   Channel   Ports                                   Handshake
//   request   req_opcode/virt_addr/phys_addr/flags    req_valid / req_ready
//   result    rsp_status/phys_result/... /invalidate  rsp_valid / rsp_ready
//   config    csr_index, csr_wdata                    csr_wr_en, no wait
//
// One operation at a time. A transfer passes through S_DIR and S_FINISH when the
// directory read settles it, and through S_DIR, S_PTE and S_FINISH when the page
// table is read (two dependent memory reads). A map that takes a new table clears
// its 1024 entries first, one per cycle, in S_SWEEP. After reset a clearing pass
// zeroes both memories with req_ready low. The result register frees the request
// side: a new transfer is taken while a result waits, and the next result holds
// until rsp_ready drains it.
module two_level_page_table_engine import tlpt_pkg::*; #(
   parameter int unsigned POOL_TABLES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_virt_addr,
   input  logic [31:0] req_phys_addr,
   input  logic [11:0] req_entry_flags,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_phys_result,
   output logic        rsp_was_accessed,
   output logic [31:0] rsp_freed_frame,
   output logic        rsp_freed_valid,
   output logic        rsp_invalidate,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0]           window_base_ff;
   logic [31:0]           window_size_ff;
   logic [FRAME_BITS-1:0] pool_frame_ff;
   dp_cmd_type            cmd;
   dp_status_type         sts;

   // Pool base keeps only its frame bits
   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff <= 32'h8000_0000;
         window_size_ff <= 32'h1000_0000;
         pool_frame_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_BASE: window_base_ff <= csr_wdata;
            CSR_WINDOW_SIZE: window_size_ff <= csr_wdata;
            CSR_POOL_BASE:   pool_frame_ff  <= csr_wdata[31:PAGE_BITS];
            default: begin
               window_base_ff <= window_base_ff;
            end
         endcase
      end
   end

   tlpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tlpt_datapath #(
      .POOL_TABLES (POOL_TABLES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_virt_addr    (req_virt_addr),
      .req_phys_addr    (req_phys_addr),
      .req_entry_flags  (req_entry_flags),
      .window_base      (window_base_ff),
      .window_size      (window_size_ff),
      .pool_frame       (pool_frame_ff),
      .rsp_status       (rsp_status),
      .rsp_phys_result  (rsp_phys_result),
      .rsp_was_accessed (rsp_was_accessed),
      .rsp_freed_frame  (rsp_freed_frame),
      .rsp_freed_valid  (rsp_freed_valid),
      .rsp_invalidate   (rsp_invalidate)
   );

endmodule

@@ tb/sv/two_level_page_table_engine_tb.sv @@
// Self-checking testbench for the two-level page table engine.
module two_level_page_table_engine_tb;
   import tlpt_pkg::*;

   localparam int unsigned POOL_TABLES = 16;
   localparam bit [31:0] PAGE_MASK   = 32'hFFFF_F000;
   localparam bit [31:0] LARGE_MASK  = 32'hFFC0_0000;
   localparam bit [31:0] LARGE_OFS   = 32'h003F_FFFF;
   localparam bit [31:0] PRESENT_BIT = 32'h1 << BIT_PRESENT;
   localparam bit [31:0] WRITE_BIT   = 32'h1 << BIT_WRITABLE;
   localparam bit [31:0] LARGE_BIT   = 32'h1 << BIT_LARGE;
   // opcodes the block does not define
   localparam bit [2:0] OP_RSVD5 = 3'd5;
   localparam bit [2:0] OP_RSVD7 = 3'd7;

   typedef struct {
      status_type  status;
      logic [31:0] phys;
      logic        acc;
      logic [31:0] freed;
      logic        freed_ok;
      logic        inv;
   } walk_result_type;

   // Shadow copy of the directory, table pool and registers; holds the results still owed.
   class page_table_shadow_type;
      bit [31:0]       dir_mem [DIR_DEPTH];
      bit [31:0]       pool_mem [POOL_TABLES * 1024];
      int unsigned     tables_used;
      bit [31:0]       win_base;
      bit [31:0]       win_size;
      bit [31:0]       pool_base;
      walk_result_type owed_results[$];
      int              errors;
      int              checked;
      int              op_count[8];

      function new();
         win_base = 32'h8000_0000;
         win_size = 32'h1000_0000;
         pool_base = '0;
         tables_used = 0;
         errors = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [1:0] idx, bit [31:0] val);
         case (idx)
            CSR_WINDOW_BASE: win_base = val;
            CSR_WINDOW_SIZE: win_size = val;
            CSR_POOL_BASE:   pool_base = val & PAGE_MASK;
            default: ;
         endcase
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      // Pool slot of the page entry for va, or -1 when the directory entry has no usable table
      function int leaf_index(bit [31:0] pde, bit [31:0] va);
         bit [31:0] k;
         if (!pde[BIT_PRESENT] || pde[BIT_LARGE]) return -1;
         k = ((pde & PAGE_MASK) - pool_base) >> PAGE_BITS;
         if (k >= POOL_TABLES) return -1;
         return int'(k) * 1024 + int'(va[21:12]);
      endfunction

      function void apply_op(bit [2:0] op, bit [31:0] va, bit [31:0] pa, bit [11:0] fl);
         walk_result_type r;
         bit [9:0]        di;
         bit [31:0]       pde;
         bit [31:0]       pte;
         bit [32:0]       win_end;
         int              slot;
         int              base;
         r.status = ST_NOT_MAPPED;
         r.phys = '0;
         r.acc = 1'b0;
         r.freed = '0;
         r.freed_ok = 1'b0;
         r.inv = 1'b0;
         di = va[31:22];
         pde = dir_mem[di];
         win_end = {1'b0, win_base} + {1'b0, win_size};
         op_count[op]++;
         case (op)
            OP_TRANSLATE: begin
               if ({1'b0, va} >= {1'b0, win_base} && {1'b0, va} < win_end) begin
                  r.status = ST_OK;
                  r.phys = va - win_base;
               end else if (pde[BIT_PRESENT] && pde[BIT_LARGE]) begin
                  r.status = ST_OK;
                  r.phys = (pde & LARGE_MASK) | (va & LARGE_OFS);
               end else begin
                  slot = leaf_index(pde, va);
                  if (slot >= 0 && pool_mem[slot][BIT_PRESENT]) begin
                     r.status = ST_OK;
                     r.phys = (pool_mem[slot] & PAGE_MASK) | {20'b0, va[11:0]};
                  end
               end
            end
            OP_MAP: begin
               if (va[11:0] != 0 || pa[11:0] != 0) begin
                  r.status = ST_MISALIGNED;
               end else if (pde[BIT_PRESENT] && pde[BIT_LARGE]) begin
                  r.status = ST_LARGE_HIT;
               end else if (!pde[BIT_PRESENT] && tables_used >= POOL_TABLES) begin
                  r.status = ST_POOL_EMPTY;
               end else begin
                  if (!pde[BIT_PRESENT]) begin
                     // hand out the next table, cleared
                     base = tables_used * 1024;
                     for (int i = 0; i < 1024; i++) pool_mem[base + i] = '0;
                     pde = ((pool_base + tables_used * 4096) & PAGE_MASK) | PRESENT_BIT
                           | WRITE_BIT;
                     tables_used++;
                     dir_mem[di] = pde;
                  end
                  slot = leaf_index(pde, va);
                  if (slot >= 0) begin
                     if (fl[BIT_USER]) dir_mem[di][BIT_USER] = 1'b1;
                     pool_mem[slot] = (pa & PAGE_MASK) | {20'b0, fl} | PRESENT_BIT;
                     r.status = ST_OK;
                     r.inv = 1'b1;
                  end
               end
            end
            OP_UNMAP: begin
               if (va[11:0] != 0) begin
                  r.status = ST_MISALIGNED;
               end else begin
                  slot = leaf_index(pde, va);
                  if (slot >= 0) begin
                     pte = pool_mem[slot];
                     if (pte[BIT_PRESENT]) begin
                        r.status = ST_OK;
                        if ((pte & PAGE_MASK) != 0 && pte[BIT_USER]) begin
                           r.freed = pte & PAGE_MASK;
                           r.freed_ok = 1'b1;
                        end
                     end
                     pool_mem[slot] = '0;
                     r.inv = 1'b1;
                  end
               end
            end
            OP_TEST_CLR: begin
               slot = leaf_index(pde, va);
               if (slot >= 0 && pool_mem[slot][BIT_PRESENT]) begin
                  r.status = ST_OK;
                  if (pool_mem[slot][BIT_ACCESSED]) begin
                     pool_mem[slot][BIT_ACCESSED] = 1'b0;
                     r.acc = 1'b1;
                     r.inv = 1'b1;
                  end
               end
            end
            OP_MAP_LARGE: begin
               if ((va & LARGE_OFS) != 0 || (pa & LARGE_OFS) != 0) begin
                  r.status = ST_MISALIGNED;
               end else begin
                  dir_mem[di] = (pa & LARGE_MASK) | {20'b0, fl} | PRESENT_BIT | LARGE_BIT;
                  r.status = ST_OK;
                  r.inv = 1'b1;
               end
            end
            default: ;
         endcase
         owed_results.push_back(r);
      endfunction

      function void compare_result(logic [2:0] st, logic [31:0] phys, logic acc,
                                   logic [31:0] freed, logic fv, logic inv);
         walk_result_type e;
         if (owed_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: result with nothing owed: status %0d phys %h", $time, st, phys);
            return;
         end
         e = owed_results.pop_front();
         checked++;
         if (st !== e.status || phys !== e.phys || acc !== e.acc || freed !== e.freed ||
             fv !== e.freed_ok || inv !== e.inv) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: result %0d differs", $time, checked);
               $display("   expected status %0d phys %h acc %b freed %h/%b inv %b",
                        e.status, e.phys, e.acc, e.freed, e.freed_ok, e.inv);
               $display("   actual   status %0d phys %h acc %b freed %h/%b inv %b",
                        st, phys, acc, freed, fv, inv);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_opcode;
   logic [31:0] req_virt_addr;
   logic [31:0] req_phys_addr;
   logic [11:0] req_entry_flags;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_phys_result;
   logic        rsp_was_accessed;
   logic [31:0] rsp_freed_frame;
   logic        rsp_freed_valid;
   logic        rsp_invalidate;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   page_table_shadow_type shadow = new();
   bit               req_idle_on;
   bit               rsp_idle_on;
   bit [9:0]         hot_dirs[$];
   bit [9:0]         large_dirs[2] = '{10'h0C0, 10'h3A0};
   bit [9:0]         hot_pages[5] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'h3FF};

   two_level_page_table_engine #(.POOL_TABLES(POOL_TABLES)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_virt_addr   (req_virt_addr),
      .req_phys_addr   (req_phys_addr),
      .req_entry_flags (req_entry_flags),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_phys_result (rsp_phys_result),
      .rsp_was_accessed(rsp_was_accessed),
      .rsp_freed_frame (rsp_freed_frame),
      .rsp_freed_valid (rsp_freed_valid),
      .rsp_invalidate  (rsp_invalidate),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(bit on);
      int r;
      if (!on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side: stall at random
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         stall = ($urandom_range(0, 3) == 0) ? pick_gap(rsp_idle_on) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         shadow.compare_result(rsp_status, rsp_phys_result, rsp_was_accessed,
                               rsp_freed_frame, rsp_freed_valid, rsp_invalidate);
   end

   // Hold valid and payload until the transfer; keep valid high when the next item follows at once.
   task automatic send_item(input bit [2:0] op, input bit [31:0] va, input bit [31:0] pa,
                            input bit [11:0] fl);
      int gap;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_virt_addr <= va;
      req_phys_addr <= pa;
      req_entry_flags <= fl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shadow.apply_op(op, va, pa, fl);
      gap = pick_gap(req_idle_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic set_window(input bit [31:0] wb, input bit [31:0] ws, input bit [31:0] pb);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_WINDOW_BASE;
      csr_wdata <= wb;
      shadow.write_reg(CSR_WINDOW_BASE, wb);
      @(posedge clock);
      csr_index <= CSR_WINDOW_SIZE;
      csr_wdata <= ws;
      shadow.write_reg(CSR_WINDOW_SIZE, ws);
      @(posedge clock);
      csr_index <= CSR_POOL_BASE;
      csr_wdata <= pb;
      shadow.write_reg(CSR_POOL_BASE, pb);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_item();
      int        r;
      bit [2:0]  op;
      bit [9:0]  di;
      bit [9:0]  pi;
      bit [11:0] ofs;
      bit [31:0] pa;
      bit [11:0] fl;
      r = $urandom_range(0, 99);
      if (r >= 94) begin
         // noise: anything at all, unknown opcodes included
         send_item(3'($urandom_range(0, 7)), $urandom, $urandom,
                   12'($urandom_range(0, 4095)));
         return;
      end
      if (r < 30) op = OP_TRANSLATE;
      else if (r < 55) op = OP_MAP;
      else if (r < 70) op = OP_UNMAP;
      else if (r < 88) op = OP_TEST_CLR;
      else op = OP_MAP_LARGE;
      r = $urandom_range(0, 99);
      if (op == OP_MAP_LARGE) begin
         di = (r < 70) ? large_dirs[$urandom_range(0, 1)] : 10'($urandom_range(0, 1023));
      end else if (r < 85) begin
         di = hot_dirs[$urandom_range(0, hot_dirs.size() - 1)];
      end else if (r < 95) begin
         di = large_dirs[$urandom_range(0, 1)];
      end else begin
         di = 10'($urandom_range(0, 1023));
      end
      pi = ($urandom_range(0, 3) != 0) ? hot_pages[$urandom_range(0, 4)]
                                       : 10'($urandom_range(0, 1023));
      ofs = 12'($urandom_range(0, 4095));
      pa = $urandom;
      fl = 12'($urandom_range(0, 4095));
      if ((op == OP_MAP || op == OP_UNMAP) && $urandom_range(0, 9) != 0) ofs = '0;
      if (op == OP_MAP && $urandom_range(0, 9) != 0) pa[11:0] = '0;
      if (op == OP_MAP_LARGE && $urandom_range(0, 9) != 0) begin
         pi = '0;
         ofs = '0;
         pa[21:0] = '0;
      end
      send_item(op, {di, pi, ofs}, pa, fl);
   endtask

   task automatic run_phase(input bit [31:0] wb, input bit [31:0] ws, input bit [31:0] pb,
                            input int n);
      drain();
      set_window(wb, ws, pb);
      repeat (n) random_item();
   endtask

   task automatic directed_items();
      send_item(OP_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000);
      send_item(OP_TRANSLATE, 32'h8000_0000, 32'h0, 12'h000);
      send_item(OP_TRANSLATE, 32'h8FFF_FFFF, 32'h0, 12'h000);
      send_item(OP_TRANSLATE, 32'h9000_0000, 32'h0, 12'h000);
      send_item(OP_MAP, 32'h0040_1000, 32'h1234_5000, 12'h024);
      send_item(OP_TRANSLATE, 32'h0040_1ABC, 32'h0, 12'h000);
      send_item(OP_TEST_CLR, 32'h0040_1FFF, 32'h0, 12'h000);
      send_item(OP_TEST_CLR, 32'h0040_1000, 32'h0, 12'h000);
      send_item(OP_MAP, 32'h0040_2001, 32'h0000_0000, 12'h000);
      send_item(OP_MAP, 32'h0040_2000, 32'h0000_0555, 12'h000);
      send_item(OP_UNMAP, 32'h0040_1000, 32'h0, 12'h000);
      // table reached, page already gone
      send_item(OP_UNMAP, 32'h0040_1000, 32'h0, 12'h000);
      send_item(OP_UNMAP, 32'h00C0_0000, 32'h0, 12'h000);
      send_item(OP_UNMAP, 32'h0040_1800, 32'h0, 12'h000);
      send_item(OP_MAP_LARGE, 32'h0080_0000, 32'hFFC0_0000, 12'hFFF);
      send_item(OP_TRANSLATE, 32'h00BF_FFFF, 32'h0, 12'h000);
      send_item(OP_MAP, 32'h0080_1000, 32'h0000_1000, 12'h000);
      send_item(OP_MAP_LARGE, 32'h0080_1000, 32'h0040_0000, 12'h000);
      send_item(OP_MAP_LARGE, 32'h00C0_0000, 32'h0040_1000, 12'h000);
      // large entry over an allocated table: the table is lost
      send_item(OP_MAP_LARGE, 32'h0040_0000, 32'h4000_0000, 12'h000);
      // user page at frame zero frees nothing
      send_item(OP_MAP, 32'h0000_0000, 32'h0000_0000, 12'h004);
      send_item(OP_UNMAP, 32'h0000_0000, 32'h0, 12'h000);
      send_item(OP_MAP, 32'hFFFF_F000, 32'hFFFF_F000, 12'hFFF);
      send_item(OP_TRANSLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
      send_item(OP_TEST_CLR, 32'hFFFF_F000, 32'h0, 12'h000);
      send_item(OP_UNMAP, 32'hFFFF_F000, 32'h0, 12'h000);
      send_item(OP_RSVD5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
      send_item(OP_RSVD7, 32'h0040_1000, 32'h1234_5000, 12'h004);
   endtask

   initial begin
      bit [9:0] di;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= '0;
      req_virt_addr <= '0;
      req_phys_addr <= '0;
      req_entry_flags <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      set_window(32'h8000_0000, 32'h1000_0000, 32'h0000_0000);
      directed_items();
      hot_dirs = '{10'h005, 10'h010, 10'h1A0, 10'h3FE};
      repeat (75) random_item();

      // new pool base with stray low bits: earlier tables now dangle
      hot_dirs = '{10'h0AB, 10'h155, 10'h2C0};
      rsp_idle_on = 1'b0;
      run_phase(32'hFFFF_F000, 32'h8000_0000, 32'h1234_5ABC, 75);

      hot_dirs = '{10'h040, 10'h200, 10'h3C1};
      req_idle_on = 1'b0;
      run_phase(32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 75);

      rsp_idle_on = 1'b1;
      run_phase(32'hFFFF_FFFF, 32'h0040_0000, 32'hFFFF_0000, 75);

      // back to pool base zero: the first tables come alive again
      hot_dirs = '{10'h005, 10'h010, 10'h1A0, 10'h3FE};
      req_idle_on = 1'b1;
      run_phase(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 75);

      // run the pool dry
      for (int k = 0; k < 20; k++) begin
         di = 10'h300 + k[9:0];
         send_item(OP_MAP, {di, 22'h0}, {20'($urandom), 12'h000}, 12'($urandom));
      end

      req_valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Covered translate %0d, map %0d, unmap %0d, test-clear %0d, map-large %0d,",
               shadow.op_count[0], shadow.op_count[1], shadow.op_count[2],
               shadow.op_count[3], shadow.op_count[4]);
      $display("undefined %0d over five register settings; %0d results checked, %0d tables used",
               shadow.op_count[5] + shadow.op_count[6] + shadow.op_count[7],
               shadow.checked, shadow.tables_used);
      if (shadow.errors == 0 && shadow.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/tlpt_pkg.sv
src/tlpt_datapath.sv
src/tlpt_ctrl.sv
src/two_level_page_table_engine.sv
tb/sv/two_level_page_table_engine_tb.sv
